/* rtl/dba_pkg.sv */
// Shared types, constants and target computation for the display brightness averager.
// No dependencies; imported by dba_window and display_brightness_averager_core.
`default_nettype none

package dba_pkg;

    localparam int LEVEL_W  = 10;
    localparam int SAMPLE_W = 12;
    localparam int REG_W    = 8;
    localparam int RAW_W    = 20;

    typedef logic [LEVEL_W-1:0]  t_level;
    typedef logic [SAMPLE_W-1:0] t_sample;
    typedef logic [REG_W-1:0]    t_reg;

    localparam t_level     LEVEL_FLOOR = 10'd125;
    localparam t_level     LEVEL_CEIL  = 10'd1000;
    localparam logic [5:0] MANUAL_STEP = 6'd35;

    localparam logic REG_MANUAL_LEVEL = 1'b0;
    localparam logic REG_SENSOR_GAIN  = 1'b1;

    function automatic t_level target_level(
        input t_reg    manual_level,
        input t_reg    sensor_gain,
        input t_sample sample
    );
        logic [RAW_W-1:0] prod;
        logic [RAW_W-1:0] raw;
        prod = RAW_W'(sample) * RAW_W'(sensor_gain);
        if (manual_level != '0) begin
            raw = RAW_W'(LEVEL_FLOOR) + RAW_W'(MANUAL_STEP) * RAW_W'(manual_level);
        end else begin
            raw = RAW_W'(LEVEL_FLOOR) + (prod >> 1);
        end
        if (raw > RAW_W'(LEVEL_CEIL)) begin
            raw = RAW_W'(LEVEL_CEIL);
        end
        return raw[LEVEL_W-1:0];
    endfunction

endpackage

`default_nettype wire

/* rtl/dba_window.sv */
// Averaging window: shift line of the last DEPTH targets and their running sum.
// Depends on dba_pkg for the level type.
`default_nettype none

module dba_window
    import dba_pkg::*;
#(
    parameter int DEPTH   = 20,
    parameter int TOTAL_W = 15
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_shift_en,
    input  wire t_level             i_target,
    output logic [TOTAL_W-1:0]      o_total
);

    t_level              r_taps [DEPTH];
    logic [TOTAL_W-1:0]  r_total;
    logic [TOTAL_W-1:0]  n_total;

    assign n_total = r_total - TOTAL_W'(r_taps[DEPTH-1]) + TOTAL_W'(i_target);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < DEPTH; i++) begin
                r_taps[i] <= '0;
            end
            r_total <= '0;
        end else if (i_shift_en) begin
            r_taps[0] <= i_target;
            for (int i = 1; i < DEPTH; i++) begin
                r_taps[i] <= r_taps[i-1];
            end
            r_total <= n_total;
        end
    end

    assign o_total = r_total;

endmodule

`default_nettype wire

/* rtl/display_brightness_averager_core.sv */
// Display brightness averager: clamped brightness target, moving average over a window.
// Four register stages lie between input accept and o_out_valid: input, target, window, output.
// Throughput: one item per cycle; stall propagates back through the four stages.
// Reset (synchronous, active low) clears the window and sum, empties all stages,
// and sets manual_level to 0 and sensor_gain to 1. Depends on dba_pkg and dba_window.
`default_nettype none

module display_brightness_averager_core
    import dba_pkg::*;
#(
    parameter int WINDOW_DEPTH = 20
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_stall,
    input  wire logic [11:0]   i_light_sample,
    output logic               o_out_valid,
    input  wire logic          i_out_stall,
    output logic [9:0]         o_pwm_duty,
    input  wire logic          i_cfg_wr_en,
    input  wire logic          i_cfg_index,
    input  wire logic [7:0]    i_cfg_data
);

    localparam int TOTAL_W = $clog2(1000 * WINDOW_DEPTH + 1);
    localparam int SHIFT   = TOTAL_W + $clog2(WINDOW_DEPTH);
    localparam longint unsigned RECIP =
        ((64'd1 << SHIFT) + WINDOW_DEPTH - 1) / WINDOW_DEPTH;
    localparam int RECIP_W = SHIFT + 1;
    localparam int PROD_W  = TOTAL_W + RECIP_W;

    t_reg    r_manual_level;
    t_reg    r_sensor_gain;

    logic    r_a_valid;
    t_sample r_a_sample;
    logic    r_b_valid;
    t_level  r_b_target;
    logic    r_c_valid;
    logic    r_out_valid;
    t_level  r_pwm_duty;

    logic    load_a;
    logic    load_b;
    logic    load_c;
    logic    load_d;

    logic [TOTAL_W-1:0] window_total;
    logic [PROD_W-1:0]  avg_prod;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_manual_level <= '0;
            r_sensor_gain  <= 8'd1;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                REG_MANUAL_LEVEL: r_manual_level <= i_cfg_data;
                REG_SENSOR_GAIN:  r_sensor_gain  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // advance a stage when it is empty or the next one takes its item
    assign load_d     = !r_out_valid || !i_out_stall;
    assign load_c     = !r_c_valid || load_d;
    assign load_b     = !r_b_valid || load_c;
    assign load_a     = !r_a_valid || load_b;
    assign o_in_stall = !load_a;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid   <= 1'b0;
            r_b_valid   <= 1'b0;
            r_c_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (load_a) begin
                r_a_valid <= i_in_valid;
            end
            if (load_b) begin
                r_b_valid <= r_a_valid;
            end
            if (load_c) begin
                r_c_valid <= r_b_valid;
            end
            if (load_d) begin
                r_out_valid <= r_c_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_a) begin
            r_a_sample <= i_light_sample;
        end
        if (load_b) begin
            r_b_target <= target_level(r_manual_level, r_sensor_gain, r_a_sample);
        end
        if (load_d) begin
            r_pwm_duty <= avg_prod[SHIFT +: LEVEL_W];
        end
    end

    dba_window #(
        .DEPTH   (WINDOW_DEPTH),
        .TOTAL_W (TOTAL_W)
    ) u_window (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_shift_en (load_c && r_b_valid),
        .i_target   (r_b_target),
        .o_total    (window_total)
    );

    // floor(total / depth) by reciprocal multiply
    assign avg_prod = PROD_W'(window_total) * PROD_W'(RECIP_W'(RECIP));

    assign o_out_valid = r_out_valid;
    assign o_pwm_duty  = r_pwm_duty;

    a_duty_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> r_pwm_duty <= LEVEL_CEIL)
        else $error("pwm duty above ceiling");

    a_target_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_b_valid |-> (r_b_target >= LEVEL_FLOOR && r_b_target <= LEVEL_CEIL))
        else $error("target out of clamp range");

    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall && r_a_valid && r_b_valid && r_c_valid)
            |-> o_in_stall)
        else $error("full pipeline accepted an item");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !r_out_valid)
        else $error("output valid after reset");

endmodule

`default_nettype wire
